FILE: src/twpb_pkg.sv
package twpb_pkg;

    localparam int STAMP_W  = 48;
    localparam int HANDLE_W = 32;
    localparam int SECS_W   = 12;
    localparam int DSECS_W  = 13;
    localparam int LIM_W    = 22;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 2;

    localparam logic [LIM_W-1:0] MS_PER_SEC = LIM_W'(1000);
    localparam logic [SECS_W-1:0] WINDOW_RESET = SECS_W'(30);

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PUSH_DONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PACKET     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAIN_NONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR_DONE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_TRIM  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic rotate;
        logic tail;
    } cell_ctl_t;

endpackage

FILE: src/twpb_cell.sv
module twpb_cell (
    input  logic                          clk,
    input  twpb_pkg::cell_ctl_t           ctl,
    input  logic [twpb_pkg::STAMP_W-1:0]  new_stamp,
    input  logic [twpb_pkg::HANDLE_W-1:0] new_handle,
    input  logic [twpb_pkg::STAMP_W-1:0]  nb_stamp,
    input  logic [twpb_pkg::HANDLE_W-1:0] nb_handle,
    input  logic [twpb_pkg::STAMP_W-1:0]  head_stamp,
    input  logic [twpb_pkg::HANDLE_W-1:0] head_handle,
    output logic [twpb_pkg::STAMP_W-1:0]  stamp,
    output logic [twpb_pkg::HANDLE_W-1:0] handle
);
    import twpb_pkg::*;

    logic [STAMP_W-1:0]  stamp_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [STAMP_W-1:0]  stamp_next;
    logic [HANDLE_W-1:0] handle_next;

    always_comb
    begin
        stamp_next  = stamp_reg;
        handle_next = handle_reg;
        if (ctl.load)
        begin
            stamp_next  = new_stamp;
            handle_next = new_handle;
        end
        else if (ctl.shift || (ctl.rotate && !ctl.tail))
        begin
            stamp_next  = nb_stamp;
            handle_next = nb_handle;
        end
        else if (ctl.rotate)
        begin
            stamp_next  = head_stamp;
            handle_next = head_handle;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg  <= stamp_next;
        handle_reg <= handle_next;
    end

    assign stamp  = stamp_reg;
    assign handle = handle_reg;

endmodule

FILE: src/time_window_packet_buffer_unit.sv
// channel  | direction | handshake                 | payload
// request  | in        | start & !busy             | command, pts_ms, payload, drain_secs
// result   | out       | result_valid, one cycle   | kind, out_pts_ms, out_payload, last,
//          |           |                           | span_ms, dropped_full
// config   | in        | cfg_we                    | cfg_wdata (window in seconds)
//
// push: loads the packet, then trims packets from the oldest end of the cell chain
// drain: the chain rotates once through cell 0, one step per stored packet;
// drain of an empty ring and clear: answered straight from idle
// a result appears the cycle after its decision; the receiver cannot stall
// reset empties the ring and sets the window to 30 s; no clearing pass
module time_window_packet_buffer_unit #(
    parameter int RING_DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [twpb_pkg::CMD_W-1:0]      command,
    input  logic [twpb_pkg::STAMP_W-1:0]    pts_ms,
    input  logic [twpb_pkg::HANDLE_W-1:0]   payload,
    input  logic signed [twpb_pkg::DSECS_W-1:0] drain_secs,
    input  logic                            cfg_we,
    input  logic [twpb_pkg::SECS_W-1:0]     cfg_wdata,
    output logic                            result_valid,
    output logic [twpb_pkg::KIND_W-1:0]     kind,
    output logic [twpb_pkg::STAMP_W-1:0]    out_pts_ms,
    output logic [twpb_pkg::HANDLE_W-1:0]   out_payload,
    output logic                            last,
    output logic [twpb_pkg::STAMP_W-1:0]    span_ms,
    output logic                            dropped_full
);
    import twpb_pkg::*;

    localparam int CW = $clog2(RING_DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SECS_W-1:0]   window_reg;
    logic [STAMP_W-1:0]  newest_reg, newest_next;
    logic [LIM_W-1:0]    lim_reg, lim_next;
    logic [STAMP_W-1:0]  span_reg, span_next;
    logic                drop_reg, drop_next;

    logic                res_valid_reg, res_valid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [STAMP_W-1:0]  opts_reg, opts_next;
    logic [HANDLE_W-1:0] opay_reg, opay_next;
    logic                last_reg, last_next;
    logic [STAMP_W-1:0]  ospan_reg, ospan_next;
    logic                odrop_reg, odrop_next;

    logic [STAMP_W-1:0]  stamp_q  [RING_DEPTH];
    logic [HANDLE_W-1:0] handle_q [RING_DEPTH];
    cell_ctl_t           ctl      [RING_DEPTH];

    logic                full;
    logic                in_win;
    logic [STAMP_W-1:0]  span_now;
    logic [CW-1:0]       fill_m1;
    logic                do_push, do_shift, do_rotate;
    logic [SECS_W-1:0]   drain_s;

    assign full    = fill_reg == CW'(RING_DEPTH);
    assign fill_m1 = fill_reg - CW'(1);
    assign in_win  = ({1'b0, stamp_q[0]} + {{(STAMP_W + 1 - LIM_W){1'b0}}, lim_reg})
                     >= {1'b0, newest_reg};
    assign span_now = (fill_reg >= CW'(2) && newest_reg >= stamp_q[0])
                      ? newest_reg - stamp_q[0] : '0;
    assign drain_s  = drain_secs[DSECS_W-1] ? window_reg : drain_secs[SECS_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        newest_next    = newest_reg;
        lim_next       = lim_reg;
        span_next      = span_reg;
        drop_next      = drop_reg;
        res_valid_next = 1'b0;
        kind_next      = kind_reg;
        opts_next      = '0;
        opay_next      = '0;
        last_next      = 1'b1;
        ospan_next     = '0;
        odrop_next     = 1'b0;
        do_push        = 1'b0;
        do_shift       = 1'b0;
        do_rotate      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        CMD_PUSH:
                        begin
                            do_push     = 1'b1;
                            do_shift    = full;
                            drop_next   = full;
                            fill_next   = full ? fill_reg : fill_reg + CW'(1);
                            newest_next = pts_ms;
                            lim_next    = LIM_W'(window_reg) * MS_PER_SEC;
                            state_next  = ST_TRIM;
                        end
                        CMD_DRAIN:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                                kind_next      = KIND_DRAIN_NONE;
                            end
                            else
                            begin
                                lim_next   = LIM_W'(drain_s) * MS_PER_SEC;
                                span_next  = span_now;
                                cnt_next   = '0;
                                state_next = ST_DRAIN;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next      = '0;
                            res_valid_next = 1'b1;
                            kind_next      = KIND_CLEAR_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TRIM:
            begin
                if (fill_reg > CW'(1) && !in_win)
                begin
                    do_shift  = 1'b1;
                    fill_next = fill_m1;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_PUSH_DONE;
                    ospan_next     = span_now;
                    odrop_next     = drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                do_rotate = 1'b1;
                if (in_win)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_PACKET;
                    opts_next      = stamp_q[0];
                    opay_next      = handle_q[0];
                    last_next      = cnt_reg == fill_m1;
                    ospan_next     = span_reg;
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == fill_m1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < RING_DEPTH; gi++)
        begin : g_cell
            always_comb
            begin
                ctl[gi].load   = do_push &&
                                 (full ? (gi == RING_DEPTH - 1) : (CW'(gi) == fill_reg));
                ctl[gi].shift  = do_shift;
                ctl[gi].rotate = do_rotate && (CW'(gi) < fill_reg);
                ctl[gi].tail   = CW'(gi) == fill_m1;
            end

            twpb_cell u_cell (
                .clk         (clk),
                .ctl         (ctl[gi]),
                .new_stamp   (pts_ms),
                .new_handle  (payload),
                .nb_stamp    (stamp_q[(gi + 1) % RING_DEPTH]),
                .nb_handle   (handle_q[(gi + 1) % RING_DEPTH]),
                .head_stamp  (stamp_q[0]),
                .head_handle (handle_q[0]),
                .stamp       (stamp_q[gi]),
                .handle      (handle_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            window_reg    <= WINDOW_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        newest_reg <= newest_next;
        lim_reg    <= lim_next;
        span_reg   <= span_next;
        drop_reg   <= drop_next;
        kind_reg   <= kind_next;
        opts_reg   <= opts_next;
        opay_reg   <= opay_next;
        last_reg   <= last_next;
        ospan_reg  <= ospan_next;
        odrop_reg  <= odrop_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = res_valid_reg;
    assign kind         = kind_reg;
    assign out_pts_ms   = opts_reg;
    assign out_payload  = opay_reg;
    assign last         = last_reg;
    assign span_ms      = ospan_reg;
    assign dropped_full = odrop_reg;

endmodule
